[rtl/nalsp_pkg.sv]
// Shared constants and types for the Annex B NAL unit splitter.
package nalsp_pkg;

	// Width of the running byte position and of stored unit offsets
	localparam int OFFSET_BITS = 32;
	// Width of the offset and length fields on the result port
	localparam int OUT_BITS    = 32;
	localparam int TYPE_BITS   = 5;

	// Descriptor queue between the scanner and the result port
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// Zero-run tracking codes
	localparam logic [1:0] ZRUN_NONE  = 2'd0;
	localparam logic [1:0] ZRUN_START = 2'd2;	// enough zeros for a start code
	localparam logic [1:0] ZRUN_MAX   = 2'd3;	// three or more zeros

	localparam logic [7:0] START_BYTE = 8'h01;

	typedef logic [OFFSET_BITS-1:0] pos_t;

	// One NAL unit descriptor
	typedef struct packed {
		logic [OUT_BITS-1:0]  offset;
		logic [OUT_BITS-1:0]  length;
		logic [TYPE_BITS-1:0] unit_type;
		logic                 type_valid;
		logic                 final_unit;
	} desc_t;

	// Descriptors produced by one byte: count is 0, 1 or 2
	typedef struct packed {
		logic [1:0] count;
		desc_t      first;
		desc_t      second;
	} scan_res_t;

endpackage

[rtl/nalsp_scan.sv]
// Start-code scanner: per-byte state update and descriptor generation.
module nalsp_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           stream_byte,
	input  logic                 end_of_stream,
	output nalsp_pkg::scan_res_t res
);

	nalsp_pkg::pos_t pos_q;
	logic [1:0]      zrun_q;
	logic            unit_open_q;
	nalsp_pkg::pos_t open_off_q;
	logic            hexp_q;
	logic [nalsp_pkg::TYPE_BITS-1:0] open_type_q;
	logic            open_tvalid_q;

	logic [nalsp_pkg::TYPE_BITS-1:0] hdr_type;
	logic            hdr_valid;
	logic            is_zero;
	logic            is_start;
	nalsp_pkg::pos_t start_pos;
	nalsp_pkg::pos_t next_pos;
	nalsp_pkg::pos_t close_len;
	nalsp_pkg::pos_t new_off;
	nalsp_pkg::pos_t eos_len;
	logic [nalsp_pkg::TYPE_BITS-1:0] new_type;
	logic            new_tvalid;
	logic            new_open;
	logic            emit_close;
	logic            emit_eos;
	logic [1:0]      zrun_d;
	nalsp_pkg::desc_t close_desc;
	nalsp_pkg::desc_t eos_desc;

	// Header capture, start-code detect and descriptor build
	always_comb begin
		hdr_type  = open_type_q;
		hdr_valid = open_tvalid_q;
		if (hexp_q) begin
			hdr_type  = stream_byte[nalsp_pkg::TYPE_BITS-1:0];
			hdr_valid = 1'b1;
		end

		is_zero   = (stream_byte == 8'h00);
		is_start  = (stream_byte == nalsp_pkg::START_BYTE) && (zrun_q >= nalsp_pkg::ZRUN_START);
		start_pos = pos_q - nalsp_pkg::OFFSET_BITS'(zrun_q);
		next_pos  = pos_q + nalsp_pkg::OFFSET_BITS'(1);
		close_len = start_pos - open_off_q;

		// Open unit after this byte
		new_open   = unit_open_q | is_start;
		new_off    = is_start ? start_pos : open_off_q;
		new_type   = is_start ? '0 : hdr_type;
		new_tvalid = is_start ? 1'b0 : hdr_valid;
		eos_len    = next_pos - new_off;

		close_desc.offset     = nalsp_pkg::OUT_BITS'(open_off_q);
		close_desc.length     = nalsp_pkg::OUT_BITS'(close_len);
		close_desc.unit_type  = hdr_valid ? hdr_type : '0;
		close_desc.type_valid = hdr_valid;
		close_desc.final_unit = 1'b0;

		eos_desc.offset     = nalsp_pkg::OUT_BITS'(new_off);
		eos_desc.length     = nalsp_pkg::OUT_BITS'(eos_len);
		eos_desc.unit_type  = new_tvalid ? new_type : '0;
		eos_desc.type_valid = new_tvalid;
		eos_desc.final_unit = 1'b1;

		emit_close = is_start & unit_open_q;
		emit_eos   = end_of_stream & new_open;

		res.first  = emit_close ? close_desc : eos_desc;
		res.second = eos_desc;
		res.count  = {1'b0, emit_close} + {1'b0, emit_eos};

		// Zero run saturates at three
		if (!is_zero) begin
			zrun_d = nalsp_pkg::ZRUN_NONE;
		end else if (zrun_q == nalsp_pkg::ZRUN_MAX) begin
			zrun_d = nalsp_pkg::ZRUN_MAX;
		end else begin
			zrun_d = zrun_q + 2'd1;
		end
	end

	// Scanner state; end of stream returns everything to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			zrun_q        <= nalsp_pkg::ZRUN_NONE;
			unit_open_q   <= 1'b0;
			open_off_q    <= '0;
			hexp_q        <= 1'b0;
			open_type_q   <= '0;
			open_tvalid_q <= 1'b0;
		end else if (accept) begin
			if (end_of_stream) begin
				pos_q         <= '0;
				zrun_q        <= nalsp_pkg::ZRUN_NONE;
				unit_open_q   <= 1'b0;
				open_off_q    <= '0;
				hexp_q        <= 1'b0;
				open_type_q   <= '0;
				open_tvalid_q <= 1'b0;
			end else begin
				pos_q         <= next_pos;
				zrun_q        <= is_start ? nalsp_pkg::ZRUN_NONE : zrun_d;
				unit_open_q   <= new_open;
				open_off_q    <= new_off;
				hexp_q        <= is_start;
				open_type_q   <= new_type;
				open_tvalid_q <= new_tvalid;
			end
		end
	end

	// A header can only be pending for an open unit
	a_hdr_needs_unit: assert property (@(posedge clk) disable iff (!arst_n)
		hexp_q |-> unit_open_q)
		else $error("header pending with no open unit");

	// Two descriptors only on the last byte of a stream
	a_two_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res.count == 2'd2) |-> end_of_stream)
		else $error("two descriptors without end of stream");

	// End of stream clears position and open unit
	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_stream) |=> (pos_q == '0) && !unit_open_q)
		else $error("state not cleared after end of stream");

endmodule

[rtl/annexb_nal_unit_splitter.sv]
// Top level: Annex B byte stream in, one NAL unit descriptor per unit out.
//
// Takes one stream byte per cycle while in_stall is low, and reports each
// NAL unit as offset, length (start code included) and nal_unit_type once
// the following start code completes, or on the byte flagged end_of_stream.
// Bytes ahead of the first start code are dropped. Descriptors pass through
// a four-entry queue, so input can keep flowing while the result side stalls;
// in_stall rises only when fewer than two queue entries are free, the most
// one byte can produce. Descriptors enter the queue as their byte is accepted.
module annexb_nal_unit_splitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  stream_byte,
	input  logic        end_of_stream,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [nalsp_pkg::OUT_BITS-1:0]  unit_offset,
	output logic [nalsp_pkg::OUT_BITS-1:0]  unit_length,
	output logic [nalsp_pkg::TYPE_BITS-1:0] unit_type,
	output logic        type_valid,
	output logic        final_unit
);

	nalsp_pkg::scan_res_t res;
	nalsp_pkg::desc_t     queue_q [nalsp_pkg::QUEUE_DEPTH];
	logic [nalsp_pkg::QPTR_BITS-1:0] wr_q;
	logic [nalsp_pkg::QPTR_BITS-1:0] rd_q;
	logic [nalsp_pkg::QCNT_BITS-1:0] count_q;
	logic [nalsp_pkg::QPTR_BITS-1:0] wr_next;
	logic [1:0] push;
	logic       in_acc;
	logic       out_acc;
	nalsp_pkg::desc_t head;

	assign in_stall = (count_q > nalsp_pkg::QCNT_BITS'(nalsp_pkg::QUEUE_DEPTH - 2));
	assign in_acc   = in_valid & ~in_stall;
	assign out_valid = (count_q != '0);
	assign out_acc  = out_valid & ~out_stall;
	assign push     = in_acc ? res.count : 2'd0;
	assign wr_next  = wr_q + nalsp_pkg::QPTR_BITS'(1);

	nalsp_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (in_acc),
		.stream_byte   (stream_byte),
		.end_of_stream (end_of_stream),
		.res           (res)
	);

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + nalsp_pkg::QPTR_BITS'(push);
			if (out_acc) begin
				rd_q <= rd_q + nalsp_pkg::QPTR_BITS'(1);
			end
			count_q <= count_q + nalsp_pkg::QCNT_BITS'(push)
				- nalsp_pkg::QCNT_BITS'(out_acc);
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push != 2'd0) begin
			queue_q[wr_q] <= res.first;
		end
		if (push == 2'd2) begin
			queue_q[wr_next] <= res.second;
		end
	end

	// Result port
	assign head        = queue_q[rd_q];
	assign unit_offset = head.offset;
	assign unit_length = head.length;
	assign unit_type   = head.unit_type;
	assign type_valid  = head.type_valid;
	assign final_unit  = head.final_unit;

	// Fill count never passes the queue depth
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= nalsp_pkg::QCNT_BITS'(nalsp_pkg::QUEUE_DEPTH))
		else $error("descriptor queue overflow");

	// A pop with nothing pushed drops the count by one
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && push == 2'd0) |=> count_q == $past(count_q) - nalsp_pkg::QCNT_BITS'(1))
		else $error("fill count wrong after pop");

	// Pointers stay apart by the fill count
	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		nalsp_pkg::QPTR_BITS'(count_q) == wr_q - rd_q)
		else $error("queue pointers disagree with fill count");

endmodule

[verif/testbench.sv]
// Self-checking testbench for the Annex B NAL unit splitter.
`timescale 1ns / 1ps

module testbench;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_stall;
	logic [7:0]                      stream_byte;
	logic                            end_of_stream;
	logic                            out_valid;
	logic                            out_stall;
	logic [nalsp_pkg::OUT_BITS-1:0]  unit_offset;
	logic [nalsp_pkg::OUT_BITS-1:0]  unit_length;
	logic [nalsp_pkg::TYPE_BITS-1:0] unit_type;
	logic                            type_valid;
	logic                            final_unit;

	annexb_nal_unit_splitter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.stream_byte   (stream_byte),
		.end_of_stream (end_of_stream),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.unit_offset   (unit_offset),
		.unit_length   (unit_length),
		.unit_type     (unit_type),
		.type_valid    (type_valid),
		.final_unit    (final_unit)
	);

	// Scanner state mirrored by the predictor
	nalsp_pkg::pos_t scan_pos;
	logic [1:0]      zero_run;
	logic            unit_active;
	nalsp_pkg::pos_t unit_start;
	logic            want_header;
	logic [4:0]      hdr_type;
	logic            hdr_seen;

	nalsp_pkg::desc_t expected_units[$];

	int             fail_count    = 0;
	int             byte_count    = 0;
	int             stream_count  = 0;
	int             units_checked = 0;
	int             tx_gap_max    = 6;
	int             rx_gap_max    = 6;
	int             hold_len      = 0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("testbench failed");
		$finish;
	end

	// Predictor
	task automatic clear_scan_state();
		scan_pos    = '0;
		zero_run    = nalsp_pkg::ZRUN_NONE;
		unit_active = 1'b0;
		unit_start  = '0;
		want_header = 1'b0;
		hdr_type    = '0;
		hdr_seen    = 1'b0;
	endtask

	task automatic close_unit(input nalsp_pkg::pos_t end_pos, input logic is_last);
		nalsp_pkg::desc_t d;
		nalsp_pkg::pos_t  len;
		len          = end_pos - unit_start;
		d.offset     = nalsp_pkg::OUT_BITS'(unit_start);
		d.length     = nalsp_pkg::OUT_BITS'(len);
		d.unit_type  = hdr_seen ? hdr_type : '0;
		d.type_valid = hdr_seen;
		d.final_unit = is_last;
		expected_units = {expected_units, d};
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic eos);
		nalsp_pkg::pos_t here;
		nalsp_pkg::pos_t code_at;
		here = scan_pos;
		// byte after a start code is the header, and still joins the zero scan
		if (want_header) begin
			hdr_type    = b[4:0];
			hdr_seen    = 1'b1;
			want_header = 1'b0;
		end
		if (b == 8'h00) begin
			if (zero_run != nalsp_pkg::ZRUN_MAX)
				zero_run = zero_run + 2'd1;
		end else if (b == nalsp_pkg::START_BYTE && zero_run >= nalsp_pkg::ZRUN_START) begin
			code_at = here - nalsp_pkg::pos_t'(zero_run);
			if (unit_active)
				close_unit(code_at, 1'b0);
			unit_active = 1'b1;
			unit_start  = code_at;
			want_header = 1'b1;
			hdr_seen    = 1'b0;
			hdr_type    = '0;
			zero_run    = nalsp_pkg::ZRUN_NONE;
		end else begin
			zero_run = nalsp_pkg::ZRUN_NONE;
		end
		scan_pos = here + nalsp_pkg::pos_t'(1);
		// end of stream closes the open unit and clears everything
		if (eos) begin
			if (unit_active)
				close_unit(scan_pos, 1'b1);
			clear_scan_state();
		end
	endtask

	// Send one byte; payload is held until accepted
	task automatic send_byte(input logic [7:0] b, input logic eos);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid      = 1'b1;
		stream_byte   = b;
		end_of_stream = eos;
		do @(posedge clk); while (in_stall);
		predict_byte(b, eos);
		byte_count++;
		if (eos)
			stream_count++;
	endtask

	// Input goes idle until every expected descriptor has come out
	task automatic pause_until_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_units.size() != 0)
			@(posedge clk);
	endtask

	// Zero-heavy random byte
	function automatic logic [7:0] noise_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return 8'h00;
		if (r == 3)
			return nalsp_pkg::START_BYTE;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_sequence(input logic [7:0] seq[$], input int pause_at);
		foreach (seq[i]) begin
			if (i == pause_at)
				pause_until_drained();
			send_byte(seq[i], i == seq.size() - 1);
		end
	endtask

	// Result side: random stall per transaction, with an optional long hold
	initial begin
		int stall_len;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			stall_len = (hold_len > 0) ? hold_len : $urandom_range(0, rx_gap_max);
			hold_len  = 0;
			repeat (stall_len) begin
				@(negedge clk);
				out_stall = 1'b1;
			end
			@(negedge clk);
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Descriptor checker
	always @(posedge clk) begin
		nalsp_pkg::desc_t d;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_units.size() == 0) begin
				$error("unexpected descriptor: offset %0h length %0h",
					unit_offset, unit_length);
				fail_count++;
			end else begin
				d = expected_units.pop_front();
				units_checked++;
				if (unit_offset !== d.offset) begin
					$error("unit_offset: expected %0h, got %0h", d.offset, unit_offset);
					fail_count++;
				end
				if (unit_length !== d.length) begin
					$error("unit_length: expected %0h, got %0h", d.length, unit_length);
					fail_count++;
				end
				if (unit_type !== d.unit_type) begin
					$error("unit_type: expected %0h, got %0h", d.unit_type, unit_type);
					fail_count++;
				end
				if (type_valid !== d.type_valid) begin
					$error("type_valid: expected %0b, got %0b", d.type_valid, type_valid);
					fail_count++;
				end
				if (final_unit !== d.final_unit) begin
					$error("final_unit: expected %0b, got %0b", d.final_unit, final_unit);
					fail_count++;
				end
			end
		end
	end

	// Stray zeros and a lone 01 byte, never a start code
	task automatic test_no_start_code();
		send_sequence('{8'h00, 8'h01, 8'h00, 8'h00, 8'hFF}, -1);
	endtask

	// Leading garbage, 3-byte code, 4-byte code, header types 5 and 31
	task automatic test_short_and_long_codes();
		send_sequence('{8'h7E, 8'h00, 8'h00, 8'h01, 8'h65,
			8'h00, 8'h00, 8'h00, 8'h01, 8'hFF}, -1);
	endtask

	// Zero header feeding a long zero run; start code on the last byte
	task automatic test_zero_header_code_at_end();
		send_sequence('{8'h00, 8'h00, 8'h01, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h01}, -1);
	endtask

	// Result side held off while back-to-back units fill the queue
	task automatic test_output_backpressure();
		logic [7:0] seq[$];
		tx_gap_max = 0;
		rx_gap_max = 0;
		repeat (40) begin
			seq = {seq, 8'h00, 8'h00, nalsp_pkg::START_BYTE};
			seq = {seq, 8'($urandom_range(0, 255))};
		end
		hold_len = 200;
		send_sequence(seq, -1);
		tx_gap_max = 6;
		rx_gap_max = 6;
	endtask

	// Input pauses with a unit open and its header still pending
	task automatic test_drain_pause();
		send_sequence('{8'h00, 8'h00, 8'h01, 8'h21, 8'hAA,
			8'h00, 8'h00, 8'h01, 8'h05, 8'hBB}, 8);
	endtask

	// Mostly well-formed streams with random content, some broken, some noise
	task automatic test_random_streams();
		logic [7:0] seq[$];
		int         stop_at;
		int         zeros;
		int         pause_at;
		stop_at = byte_count + 1300;
		while (byte_count < stop_at) begin
			seq.delete();
			tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
			rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
			if ($urandom_range(0, 4) != 0) begin
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 4)) seq = {seq, 8'($urandom_range(2, 255))};
				repeat ($urandom_range(1, 6)) begin
					case ($urandom_range(0, 5))
						0, 1, 2: zeros = 2;
						3, 4:    zeros = 3;
						default: zeros = $urandom_range(4, 7);
					endcase
					repeat (zeros) seq = {seq, 8'h00};
					seq = {seq, nalsp_pkg::START_BYTE};
					seq = {seq, 8'($urandom_range(0, 255))};
					repeat ($urandom_range(0, 10)) seq = {seq, noise_byte()};
				end
				// stream ending on a start code, with or without its header
				if ($urandom_range(0, 5) == 0) begin
					seq = {seq, 8'h00, 8'h00, nalsp_pkg::START_BYTE};
					if ($urandom_range(0, 1) == 0)
						seq = {seq, 8'($urandom_range(0, 255))};
				end
				// broken sequence: one byte replaced
				if ($urandom_range(0, 9) == 0)
					seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(0, 255));
			end else begin
				repeat ($urandom_range(1, 24)) seq = {seq, noise_byte()};
			end
			pause_at = ($urandom_range(0, 15) == 0) ? $urandom_range(0, seq.size() - 1) : -1;
			send_sequence(seq, pause_at);
		end
	endtask

	// Main sequence
	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		stream_byte   = 8'h00;
		end_of_stream = 1'b0;
		clear_scan_state();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_no_start_code();
		test_short_and_long_codes();
		test_zero_header_code_at_end();
		test_output_backpressure();
		test_drain_pause();
		test_random_streams();

		pause_until_drained();
		repeat (20) @(posedge clk);

		$display("Sent %0d bytes in %0d streams; %0d unit descriptors checked.",
			byte_count, stream_count, units_checked);
		$display("Covered 3/4-byte and long start codes, end-of-stream cases, backpressure.");
		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
